FILE: design/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants
// Widths of the coordinate datapath, the result format and the pipeline
// depths used by the segment intersection core.
// ----------------------------------------------------------------------------
package sip_pkg;

    localparam int COORD_BITS = 12;               // input grid coordinate width
    localparam int OUT_BITS   = 28;               // result coordinate width
    localparam int DIFF_W     = COORD_BITS + 1;   // coordinate difference
    localparam int PROD_W     = 2 * COORD_BITS + 2;
    localparam int ORIENT_W   = 2 * COORD_BITS + 3;
    localparam int C_W        = 2 * COORD_BITS + 2;  // line constant C
    localparam int DET_W      = 2 * COORD_BITS + 3;  // determinant
    localparam int NUM_W      = 3 * COORD_BITS + 4;  // crossing numerator
    localparam int GEOM_LAT   = 6;                // front end stages
    localparam int DIV_LAT    = OUT_BITS + 1;     // range check + one bit a stage

    typedef struct packed {
        logic signed [COORD_BITS-1:0] p1_x;
        logic signed [COORD_BITS-1:0] p1_y;
        logic signed [COORD_BITS-1:0] p2_x;
        logic signed [COORD_BITS-1:0] p2_y;
        logic signed [COORD_BITS-1:0] q1_x;
        logic signed [COORD_BITS-1:0] q1_y;
        logic signed [COORD_BITS-1:0] q2_x;
        logic signed [COORD_BITS-1:0] q2_y;
    } t_seg_in;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } t_seg_out;

    // Control that travels beside the divider.
    typedef struct packed {
        logic                       valid;
        logic                       hit;
        logic                       use_div;  // point comes from the quotients
        logic                       neg_x;
        logic                       neg_y;
        logic signed [OUT_BITS-1:0] end_x;    // endpoint contact, fixed point
        logic signed [OUT_BITS-1:0] end_y;
    } t_side;

endpackage

FILE: design/segment_intersection_point_core.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_core: line segment intersection point
// Takes segments P1-P2 and Q1-Q2 on a signed integer grid and returns
// whether they meet and the meeting point in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_seg and pulse start; a pair is taken at every rising edge with
//   start high and busy low. busy is always low: the core is a fully
//   pipelined datapath and takes a new pair in every cycle.
//   Each pair gives one result on o_res, marked by o_valid for exactly one
//   cycle, in the order the pairs were taken.
//   From the transfer to o_valid a pair passes 6 front end stages
//   (differences, products, orientation codes, numerator products,
//   numerators, magnitudes), 29 divider stages (a range check and one
//   quotient bit per stage for the 28-bit result), and the output register.
//   Throughput is one pair per cycle; both coordinates are divided in two
//   parallel divider pipelines.
//   No hit gives a zero point. Points beyond the 28-bit range saturate.
//   Synchronous reset clears every valid bit; pairs in flight are dropped.
//   The receiver cannot stall, so nothing ever holds in the pipeline.
// ----------------------------------------------------------------------------
module segment_intersection_point_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sip_pkg::t_seg_in    i_seg,
    output logic                o_valid,
    output sip_pkg::t_seg_out   o_res
);

    localparam int OB  = sip_pkg::OUT_BITS;
    localparam int NUM = sip_pkg::NUM_W;
    localparam int DEN = sip_pkg::DET_W;
    localparam int NW  = NUM + FRAC_BITS;
    localparam int DL  = sip_pkg::DIV_LAT;
    localparam logic [OB-1:0] QMAX = {1'b0, {(OB-1){1'b1}}};
    localparam logic [OB-1:0] QMIN = {1'b1, {(OB-1){1'b0}}};

    // Clamp a quotient magnitude with its sign into the signed result range.
    function automatic logic signed [OB-1:0] sat_q(input logic [OB-1:0] q,
                                                   input logic ovf,
                                                   input logic neg);
        logic [OB-1:0] v;
        if (!neg) begin
            v = (ovf || q[OB-1]) ? QMAX : q;
        end else if (ovf || (q[OB-1] && (q[OB-2:0] != '0))) begin
            v = QMIN;
        end else begin
            v = -q;
        end
        return v;
    endfunction

    sip_pkg::t_side     w_side;
    logic [NUM-1:0]     w_num_x, w_num_y;
    logic [DEN-1:0]     w_den;
    logic               w_divx_vld, w_divy_vld;
    logic               w_ovf_x, w_ovf_y;
    logic [OB-1:0]      w_quo_x, w_quo_y;

    sip_pkg::t_side     r_side [0:DL-1];
    sip_pkg::t_side     w_last;
    sip_pkg::t_seg_out  n_res, r_res;
    logic               r_valid;

    // Never stall the front: every cycle is a free slot.
    assign busy = 1'b0;

    sip_geom #(
        .FRAC_BITS (FRAC_BITS)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_seg   (i_seg),
        .o_side  (w_side),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_den   (w_den)
    );

    // Scale the numerators by 2^FRAC_BITS on the way in; truncating division
    // of magnitudes gives rounding toward zero once the sign is restored.
    sip_div #(
        .NW (NW),
        .DW (DEN),
        .QB (OB)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_side.valid),
        .i_num   (NW'(w_num_x) << FRAC_BITS),
        .i_den   (w_den),
        .o_vld   (w_divx_vld),
        .o_ovf   (w_ovf_x),
        .o_quo   (w_quo_x)
    );

    sip_div #(
        .NW (NW),
        .DW (DEN),
        .QB (OB)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_side.valid),
        .i_num   (NW'(w_num_y) << FRAC_BITS),
        .i_den   (w_den),
        .o_vld   (w_divy_vld),
        .o_ovf   (w_ovf_y),
        .o_quo   (w_quo_y)
    );

    // Carry the branch decision and endpoint contact beside the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DL; i++) begin
                r_side[i].valid <= 1'b0;
            end
        end else begin
            r_side[0] <= w_side;
            for (int i = 1; i < DL; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign w_last = r_side[DL-1];

    // Pick the crossing quotient, the endpoint contact or a zero point.
    always_comb begin
        n_res     = '0;
        n_res.hit = w_last.hit;
        if (w_last.hit && w_last.use_div) begin
            n_res.cross_x = sat_q(w_quo_x, w_ovf_x, w_last.neg_x);
            n_res.cross_y = sat_q(w_quo_y, w_ovf_y, w_last.neg_y);
        end else if (w_last.hit) begin
            n_res.cross_x = w_last.end_x;
            n_res.cross_y = w_last.end_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // dividers and side line stay in step
    a_div_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_divx_vld == w_last.valid && w_divy_vld == w_last.valid)
        else $error("divider out of step with side line");

    // a transfer out always comes from the end of the side line
    a_out_from_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_last.valid))
        else $error("result strobe without item in flight");

    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.hit |-> o_res.cross_x == '0 && o_res.cross_y == '0)
        else $error("miss with nonzero point");

endmodule

FILE: design/sip_geom.sv
// ----------------------------------------------------------------------------
// sip_geom: geometry front end
// Six stage pipeline: differences, products, orientation codes and line
// constants, numerator products with branch choice, numerators, magnitudes.
// ----------------------------------------------------------------------------
module sip_geom #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  sip_pkg::t_seg_in             i_seg,
    output sip_pkg::t_side               o_side,
    output logic [sip_pkg::NUM_W-1:0]    o_num_x,
    output logic [sip_pkg::NUM_W-1:0]    o_num_y,
    output logic [sip_pkg::DET_W-1:0]    o_den
);

    localparam int CB  = sip_pkg::COORD_BITS;
    localparam int DW  = sip_pkg::DIFF_W;
    localparam int PW  = sip_pkg::PROD_W;
    localparam int OW  = sip_pkg::ORIENT_W;
    localparam int CW  = sip_pkg::C_W;
    localparam int TW  = sip_pkg::DET_W;
    localparam int NW  = sip_pkg::NUM_W;
    localparam int OB  = sip_pkg::OUT_BITS;
    localparam logic signed [63:0] OMAX = (64'sd1 <<< (OB - 1)) - 64'sd1;
    localparam logic signed [63:0] OMIN = -OMAX - 64'sd1;

    function automatic logic in_box(
        input logic signed [CB-1:0] ax, input logic signed [CB-1:0] ay,
        input logic signed [CB-1:0] bx, input logic signed [CB-1:0] by,
        input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy);
        logic signed [CB-1:0] lox, hix, loy, hiy;
        lox = (ax < cx) ? ax : cx;
        hix = (ax < cx) ? cx : ax;
        loy = (ay < cy) ? ay : cy;
        hiy = (ay < cy) ? cy : ay;
        return (bx >= lox) && (bx <= hix) && (by >= loy) && (by <= hiy);
    endfunction

    function automatic logic signed [OB-1:0] to_fix(input logic signed [CB-1:0] v);
        logic signed [63:0] w;
        w = 64'(v) <<< FRAC_BITS;
        if (w > OMAX) begin
            w = OMAX;
        end else if (w < OMIN) begin
            w = OMIN;
        end
        return OB'(w);
    endfunction

    // orientation codes differ: zero against nonzero, or opposite signs
    function automatic logic code_ne(input logic za, input logic na,
                                     input logic zb, input logic nb);
        return !((za && zb) || (!za && !zb && (na == nb)));
    endfunction

    // stage 1
    logic                 r1_vld;
    sip_pkg::t_seg_in     r1_seg;
    logic signed [DW-1:0] r1_pdx, r1_pdy, r1_qdx, r1_qdy;
    logic signed [DW-1:0] r1_ex [0:3];
    logic signed [DW-1:0] r1_ey [0:3];
    // stage 2
    logic                 r2_vld;
    sip_pkg::t_seg_in     r2_seg;
    logic signed [DW-1:0] r2_pdx, r2_pdy, r2_qdx, r2_qdy;
    logic signed [PW-1:0] r2_ma [0:3];
    logic signed [PW-1:0] r2_mb [0:3];
    logic signed [PW-1:0] r2_c1a, r2_c1b, r2_c2a, r2_c2b, r2_da, r2_db;
    logic [3:0]           r2_tch;
    // stage 3
    logic                 r3_vld;
    sip_pkg::t_seg_in     r3_seg;
    logic signed [DW-1:0] r3_pdx, r3_pdy, r3_qdx, r3_qdy;
    logic [3:0]           r3_z, r3_n, r3_tch;
    logic signed [CW-1:0] r3_c1, r3_c2;
    logic signed [TW-1:0] r3_det;
    // stage 4
    logic                 r4_vld;
    sip_pkg::t_side       r4_side;
    logic signed [NW-1:0] r4_pxc2, r4_qxc1, r4_pyc2, r4_qyc1;
    logic signed [TW-1:0] r4_det;
    // stage 5
    logic                 r5_vld;
    sip_pkg::t_side       r5_side;
    logic signed [NW-1:0] r5_nx, r5_ny;
    logic signed [TW-1:0] r5_det;
    // stage 6
    logic                 r6_vld;
    sip_pkg::t_side       r6_side;
    logic [NW-1:0]        r6_mx, r6_my;
    logic [TW-1:0]        r6_md;

    logic signed [OW-1:0] n3_ov [0:3];
    sip_pkg::t_side       n4_side;
    logic                 n4_cross;
    sip_pkg::t_side       n6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    // stage 1: direction vectors and endpoint offsets
    always_ff @(posedge i_clk) begin
        r1_seg   <= i_seg;
        r1_pdx   <= DW'(i_seg.p2_x) - DW'(i_seg.p1_x);
        r1_pdy   <= DW'(i_seg.p2_y) - DW'(i_seg.p1_y);
        r1_qdx   <= DW'(i_seg.q2_x) - DW'(i_seg.q1_x);
        r1_qdy   <= DW'(i_seg.q2_y) - DW'(i_seg.q1_y);
        r1_ex[0] <= DW'(i_seg.q1_x) - DW'(i_seg.p2_x);
        r1_ey[0] <= DW'(i_seg.q1_y) - DW'(i_seg.p2_y);
        r1_ex[1] <= DW'(i_seg.q2_x) - DW'(i_seg.p2_x);
        r1_ey[1] <= DW'(i_seg.q2_y) - DW'(i_seg.p2_y);
        r1_ex[2] <= DW'(i_seg.p1_x) - DW'(i_seg.q2_x);
        r1_ey[2] <= DW'(i_seg.p1_y) - DW'(i_seg.q2_y);
        r1_ex[3] <= DW'(i_seg.p2_x) - DW'(i_seg.q2_x);
        r1_ey[3] <= DW'(i_seg.p2_y) - DW'(i_seg.q2_y);
    end

    // stage 2: cross products and bounding box tests
    always_ff @(posedge i_clk) begin
        r2_seg   <= r1_seg;
        r2_pdx   <= r1_pdx;
        r2_pdy   <= r1_pdy;
        r2_qdx   <= r1_qdx;
        r2_qdy   <= r1_qdy;
        r2_ma[0] <= PW'(r1_pdy) * PW'(r1_ex[0]);
        r2_mb[0] <= PW'(r1_pdx) * PW'(r1_ey[0]);
        r2_ma[1] <= PW'(r1_pdy) * PW'(r1_ex[1]);
        r2_mb[1] <= PW'(r1_pdx) * PW'(r1_ey[1]);
        r2_ma[2] <= PW'(r1_qdy) * PW'(r1_ex[2]);
        r2_mb[2] <= PW'(r1_qdx) * PW'(r1_ey[2]);
        r2_ma[3] <= PW'(r1_qdy) * PW'(r1_ex[3]);
        r2_mb[3] <= PW'(r1_qdx) * PW'(r1_ey[3]);
        r2_c1a   <= PW'(r1_pdy) * PW'(r1_seg.p1_x);
        r2_c1b   <= PW'(r1_pdx) * PW'(r1_seg.p1_y);
        r2_c2a   <= PW'(r1_qdy) * PW'(r1_seg.q1_x);
        r2_c2b   <= PW'(r1_qdx) * PW'(r1_seg.q1_y);
        r2_da    <= PW'(r1_qdy) * PW'(r1_pdx);
        r2_db    <= PW'(r1_pdy) * PW'(r1_qdx);
        r2_tch[0] <= in_box(r1_seg.p1_x, r1_seg.p1_y, r1_seg.q1_x, r1_seg.q1_y,
                            r1_seg.p2_x, r1_seg.p2_y);
        r2_tch[1] <= in_box(r1_seg.p1_x, r1_seg.p1_y, r1_seg.q2_x, r1_seg.q2_y,
                            r1_seg.p2_x, r1_seg.p2_y);
        r2_tch[2] <= in_box(r1_seg.q1_x, r1_seg.q1_y, r1_seg.p1_x, r1_seg.p1_y,
                            r1_seg.q2_x, r1_seg.q2_y);
        r2_tch[3] <= in_box(r1_seg.q1_x, r1_seg.q1_y, r1_seg.p2_x, r1_seg.p2_y,
                            r1_seg.q2_x, r1_seg.q2_y);
    end

    // stage 3: orientation codes, line constants, determinant
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n3_ov[k] = OW'(r2_ma[k]) - OW'(r2_mb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r3_seg <= r2_seg;
        r3_pdx <= r2_pdx;
        r3_pdy <= r2_pdy;
        r3_qdx <= r2_qdx;
        r3_qdy <= r2_qdy;
        r3_tch <= r2_tch;
        for (int k = 0; k < 4; k++) begin
            r3_z[k] <= (n3_ov[k] == '0);
            r3_n[k] <= n3_ov[k][OW-1];
        end
        r3_c1  <= CW'(r2_c1a) - CW'(r2_c1b);
        r3_c2  <= CW'(r2_c2a) - CW'(r2_c2b);
        r3_det <= TW'(r2_da) - TW'(r2_db);
    end

    // stage 4: numerator products, branch choice, endpoint contact
    always_comb begin
        n4_cross = code_ne(r3_z[0], r3_n[0], r3_z[1], r3_n[1]) &&
                   code_ne(r3_z[2], r3_n[2], r3_z[3], r3_n[3]);
        n4_side         = '0;
        n4_side.valid   = r3_vld;
        n4_side.use_div = n4_cross && (r3_det != '0);
        if (n4_cross) begin
            n4_side.hit = n4_side.use_div;
        end else if (r3_z[0] && r3_tch[0]) begin
            n4_side.hit   = 1'b1;
            n4_side.end_x = to_fix(r3_seg.q1_x);
            n4_side.end_y = to_fix(r3_seg.q1_y);
        end else if (r3_z[1] && r3_tch[1]) begin
            n4_side.hit   = 1'b1;
            n4_side.end_x = to_fix(r3_seg.q2_x);
            n4_side.end_y = to_fix(r3_seg.q2_y);
        end else if (r3_z[2] && r3_tch[2]) begin
            n4_side.hit   = 1'b1;
            n4_side.end_x = to_fix(r3_seg.p1_x);
            n4_side.end_y = to_fix(r3_seg.p1_y);
        end else if (r3_z[3] && r3_tch[3]) begin
            n4_side.hit   = 1'b1;
            n4_side.end_x = to_fix(r3_seg.p2_x);
            n4_side.end_y = to_fix(r3_seg.p2_y);
        end
    end

    always_ff @(posedge i_clk) begin
        r4_side <= n4_side;
        r4_det  <= r3_det;
        r4_pxc2 <= NW'(r3_pdx) * NW'(r3_c2);
        r4_qxc1 <= NW'(r3_qdx) * NW'(r3_c1);
        r4_pyc2 <= NW'(r3_pdy) * NW'(r3_c2);
        r4_qyc1 <= NW'(r3_qdy) * NW'(r3_c1);
    end

    // stage 5: numerators
    always_ff @(posedge i_clk) begin
        r5_side <= r4_side;
        r5_det  <= r4_det;
        r5_nx   <= r4_pxc2 - r4_qxc1;
        r5_ny   <= r4_pyc2 - r4_qyc1;
    end

    // stage 6: magnitudes and quotient signs
    always_comb begin
        n6_side       = r5_side;
        n6_side.neg_x = r5_nx[NW-1] ^ r5_det[TW-1];
        n6_side.neg_y = r5_ny[NW-1] ^ r5_det[TW-1];
    end

    always_ff @(posedge i_clk) begin
        r6_side <= n6_side;
        r6_mx   <= r5_nx[NW-1] ? NW'(-r5_nx) : NW'(r5_nx);
        r6_my   <= r5_ny[NW-1] ? NW'(-r5_ny) : NW'(r5_ny);
        r6_md   <= r5_det[TW-1] ? TW'(-r5_det) : TW'(r5_det);
    end

    always_comb begin
        o_side       = r6_side;
        o_side.valid = r6_vld;
    end
    assign o_num_x = r6_mx;
    assign o_num_y = r6_my;
    assign o_den   = r6_md;

endmodule

FILE: design/sip_div.sv
// ----------------------------------------------------------------------------
// sip_div: pipelined restoring divider
// One range check stage, then one quotient bit per stage, MSB first.
// o_ovf flags a quotient that does not fit in QB bits.
// ----------------------------------------------------------------------------
module sip_div #(
    parameter int NW = 56,
    parameter int DW = 27,
    parameter int QB = 28
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_vld,
    output logic          o_ovf,
    output logic [QB-1:0] o_quo
);

    localparam int HW   = NW - QB;
    localparam int CMPW = (HW > DW) ? HW : DW;

    logic          r_vld [0:QB];
    logic          r_ovf [0:QB];
    logic [DW-1:0] r_d   [0:QB];
    logic [DW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_lo  [0:QB];
    logic [QB-1:0] r_q   [0:QB];

    logic [CMPW-1:0] n_hi, n_d;

    assign n_hi = CMPW'(i_num[NW-1:QB]);
    assign n_d  = CMPW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    // upper part of the dividend at or above the divisor: quotient too wide
    always_ff @(posedge i_clk) begin
        r_ovf[0] <= (n_hi >= n_d);
        r_rem[0] <= DW'(n_hi);
        r_d[0]   <= i_den;
        r_lo[0]  <= i_num[QB-1:0];
        r_q[0]   <= '0;
    end

    for (genvar i = 0; i < QB; i++) begin : g_step
        logic [DW:0] n_t;
        logic        n_ge;

        always_comb begin
            n_t  = {r_rem[i], r_lo[i][QB-1]};
            n_ge = (n_t >= {1'b0, r_d[i]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_ovf[i+1] <= r_ovf[i];
            r_d[i+1]   <= r_d[i];
            r_lo[i+1]  <= r_lo[i] << 1;
            r_q[i+1]   <= {r_q[i][QB-2:0], n_ge};
            r_rem[i+1] <= n_ge ? DW'(n_t - {1'b0, r_d[i]}) : n_t[DW-1:0];
        end
    end

    assign o_vld = r_vld[QB];
    assign o_ovf = r_ovf[QB];
    assign o_quo = r_q[QB];

    // partial remainder always below the divisor on an in-range quotient
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QB] && !r_ovf[QB] |-> r_rem[QB] < r_d[QB])
        else $error("divider remainder not below divisor");

endmodule
